// ===== hdl/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
`default_nettype none
package bba_pkg;

    localparam int POOL_BLOCKS_DEF = 1024;
    localparam int ORDER_SLOTS_DEF = 11;
    localparam int ORD_W           = 4;   // orders up to 15

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_INIT  = 2'd2;

    localparam int REG_TOTAL = 0;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_REJECT = 2'd1,
        ST_NOFREE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_IPUSH,
        S_ASRCH,
        S_APOP,
        S_ASPLIT,
        S_FCHK,
        S_FWALK,
        S_FNEXT,
        S_FUNL,
        S_FPUSH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load_req;
        logic    init_start;
        logic    init_push;
        logic    alloc_start;
        logic    srch_inc;
        logic    pop_rd;
        logic    pop_wr;
        logic    split_push;
        logic    alloc_fin;
        logic    free_start;
        logic    chk_start;
        logic    walk_rd;
        logic    hit_rd;
        logic    next_ld;
        logic    unl;
        logic    free_push;
        logic    set_st;
        t_status st;
        logic    res_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       alloc_bad;
        logic       free_bad;
        logic       init_bad;
        logic       rem_zero;
        logic       srch_end;
        logic       head_empty;
        logic       split_end;
        logic       chk_top;
        logic       walk_end;
        logic       walk_hit;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator: APB register, sequencer and datapath.
// One request word at a time, one result word per request. Init pushes the
// pool onto the free lists as power-of-two pieces; allocate searches orders
// upward, pops a block and splits off halves; free walks the list of each
// merge level for the buddy and unlinks it before moving up. The list walk
// through the link memory, in states S_FWALK and S_FNEXT, sets the free latency.
// The result register lets the next request be taken while a result waits.
`default_nettype none
module buddy_block_allocator #(
    parameter int POOL_BLOCKS = bba_pkg::POOL_BLOCKS_DEF,
    parameter int ORDER_SLOTS = bba_pkg::ORDER_SLOTS_DEF,
    localparam int IDX_W  = $clog2(POOL_BLOCKS),
    localparam int LINK_W = $clog2(POOL_BLOCKS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [LINK_W-1:0] i_req_size,
    input  wire logic [IDX_W-1:0]  i_req_base,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_status,
    output logic [IDX_W-1:0]       o_alloc_index,
    output logic [LINK_W-1:0]      o_free_count
);
    import bba_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic        cfg_wr;
    logic        sel_total;
    logic [31:0] cfg_rdata;

    assign sel_total = (paddr[2] == 1'(REG_TOTAL));
    assign cfg_wr    = psel && penable && pwrite && sel_total;
    assign pready    = 1'b1;
    assign prdata    = sel_total ? cfg_rdata : 32'd0;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bba_dpath #(
        .POOL_BLOCKS (POOL_BLOCKS),
        .ORDER_SLOTS (ORDER_SLOTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr      (cfg_wr),
        .i_cfg_data    (pwdata),
        .o_cfg_rdata   (cfg_rdata),
        .i_req_type    (i_req_type),
        .i_req_size    (i_req_size),
        .i_req_base    (i_req_base),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_alloc_index (o_alloc_index),
        .o_free_count  (o_free_count)
    );

endmodule
`default_nettype wire

// ===== hdl/bba_ctrl.sv =====
// Request sequencer for the buddy allocator.
`default_nettype none
module bba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire bba_pkg::t_sts i_sts,
    output bba_pkg::t_cmd      o_cmd
);
    import bba_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                case (i_sts.req)
                    REQ_ALLOC: n_state = i_sts.alloc_bad ? S_DONE : S_ASRCH;
                    REQ_FREE:  n_state = i_sts.free_bad ? S_DONE : S_FCHK;
                    REQ_INIT:  n_state = i_sts.init_bad ? S_DONE : S_IPUSH;
                    default:   n_state = S_DONE;
                endcase
            end
            S_IPUSH:  if (i_sts.rem_zero) n_state = S_DONE;
            S_ASRCH: begin
                if (i_sts.srch_end) n_state = S_DONE;
                else if (!i_sts.head_empty) n_state = S_APOP;
            end
            S_APOP:   n_state = S_ASPLIT;
            S_ASPLIT: if (i_sts.split_end) n_state = S_DONE;
            S_FCHK:   n_state = i_sts.chk_top ? S_FPUSH : S_FWALK;
            S_FWALK: begin
                if (i_sts.walk_end) n_state = S_FPUSH;
                else if (i_sts.walk_hit) n_state = S_FUNL;
                else n_state = S_FNEXT;
            end
            S_FNEXT:  n_state = S_FWALK;
            S_FUNL:   n_state = S_FCHK;
            S_FPUSH:  n_state = S_DONE;
            S_DONE:   if (i_sts.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.st = ST_DONE;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE:   o_cmd.load_req = i_in_valid;
            S_DECODE: begin
                case (i_sts.req)
                    REQ_ALLOC: begin
                        o_cmd.alloc_start = !i_sts.alloc_bad;
                        o_cmd.set_st = i_sts.alloc_bad;
                    end
                    REQ_FREE: begin
                        o_cmd.free_start = !i_sts.free_bad;
                        o_cmd.set_st = i_sts.free_bad;
                    end
                    REQ_INIT: begin
                        o_cmd.init_start = !i_sts.init_bad;
                        o_cmd.set_st = i_sts.init_bad;
                    end
                    default:  o_cmd.set_st = 1'b1;
                endcase
                o_cmd.st = ST_REJECT;
            end
            S_IPUSH: begin
                o_cmd.init_push = !i_sts.rem_zero;
                o_cmd.set_st = i_sts.rem_zero;
            end
            S_ASRCH: begin
                if (i_sts.srch_end) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st = ST_NOFREE;
                end else if (i_sts.head_empty) begin
                    o_cmd.srch_inc = 1'b1;
                end else begin
                    o_cmd.pop_rd = 1'b1;
                end
            end
            S_APOP:   o_cmd.pop_wr = 1'b1;
            S_ASPLIT: begin
                o_cmd.split_push = !i_sts.split_end;
                o_cmd.alloc_fin = i_sts.split_end;
                o_cmd.set_st = i_sts.split_end;
            end
            S_FCHK:   o_cmd.chk_start = !i_sts.chk_top;
            S_FWALK: begin
                if (!i_sts.walk_end) begin
                    o_cmd.hit_rd = i_sts.walk_hit;
                    o_cmd.walk_rd = !i_sts.walk_hit;
                end
            end
            S_FNEXT:  o_cmd.next_ld = 1'b1;
            S_FUNL:   o_cmd.unl = 1'b1;
            S_FPUSH: begin
                o_cmd.free_push = 1'b1;
                o_cmd.set_st = 1'b1;
            end
            S_DONE:   o_cmd.res_load = i_sts.out_free;
            default:  o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/bba_dpath.sv =====
// Datapath of the buddy allocator: free-list heads, link memory, counters.
`default_nettype none
module bba_dpath #(
    parameter int POOL_BLOCKS = bba_pkg::POOL_BLOCKS_DEF,
    parameter int ORDER_SLOTS = bba_pkg::ORDER_SLOTS_DEF,
    localparam int IDX_W  = $clog2(POOL_BLOCKS),
    localparam int LINK_W = $clog2(POOL_BLOCKS + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bba_pkg::t_cmd       i_cmd,
    output bba_pkg::t_sts            o_sts,
    input  wire logic                i_cfg_wr,
    input  wire logic [31:0]         i_cfg_data,
    output logic [31:0]              o_cfg_rdata,
    input  wire logic [1:0]          i_req_type,
    input  wire logic [LINK_W-1:0]   i_req_size,
    input  wire logic [IDX_W-1:0]    i_req_base,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [1:0]               o_status,
    output logic [IDX_W-1:0]         o_alloc_index,
    output logic [LINK_W-1:0]        o_free_count
);
    import bba_pkg::*;

    localparam int SLOT_W = $clog2(ORDER_SLOTS);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_BLOCKS);

    typedef logic [LINK_W-1:0] t_heads [ORDER_SLOTS];

    function automatic logic [LINK_W-1:0] head_at(input t_heads h, input logic [ORD_W-1:0] o);
        logic [LINK_W-1:0] v;
        v = NIL;
        if ({1'b0, o} < 5'(ORDER_SLOTS)) v = h[o[SLOT_W-1:0]];
        return v;
    endfunction

    logic [LINK_W-1:0] r_mem [POOL_BLOCKS];
    logic [LINK_W-1:0] r_rdata;
    t_heads            r_head;
    logic [LINK_W-1:0] r_total;
    logic [ORD_W-1:0]  r_limit;
    logic [LINK_W-1:0] r_fc;
    logic [1:0]        r_req;
    logic [LINK_W-1:0] r_n;
    logic [IDX_W-1:0]  r_bidx;
    logic [ORD_W-1:0]  r_ord, r_found;
    logic [IDX_W-1:0]  r_blk, r_idx, r_prev, r_where;
    logic [LINK_W-1:0] r_size, r_cur, r_steps, r_rem, r_at;
    logic              r_hasprev;
    t_status           r_status;
    logic              r_ovalid;
    t_status           r_o_status;
    logic [IDX_W-1:0]  r_o_where;
    logic [LINK_W-1:0] r_o_fc;

    logic [LINK_W-1:0] nm1;
    logic [ORD_W-1:0]  clog_n, clog_t, init_o;
    logic [4:0]        limit5;
    logic [LINK_W-1:0] tm1;
    logic [LINK_W-1:0] head_found, head_ord, head_split, head_init;
    logic [ORD_W-1:0]  found_dn;
    logic [IDX_W-1:0]  bud;
    logic [LINK_W:0]   split_at;
    logic [LINK_W:0]   alloc_sz, fsum;
    logic              we;
    logic [IDX_W-1:0]  waddr, raddr;
    logic [LINK_W-1:0] wdata;

    // ceil log2 via top set bit of n-1; floor log2 of the remainder for init
    always_comb begin
        nm1 = r_n - LINK_W'(1);
        tm1 = r_total - LINK_W'(1);
        clog_n = '0;
        clog_t = '0;
        init_o = '0;
        for (int i = 0; i < LINK_W; i++) begin
            if (nm1[i]) clog_n = ORD_W'(i + 1);
            if (tm1[i]) clog_t = ORD_W'(i + 1);
            if (r_rem[i]) init_o = ORD_W'(i);
        end
        limit5 = {1'b0, clog_t} + 5'd1;
    end

    always_comb begin
        found_dn   = r_found - ORD_W'(1);
        head_found = head_at(r_head, r_found);
        head_ord   = head_at(r_head, r_ord);
        head_split = head_at(r_head, found_dn);
        head_init  = head_at(r_head, init_o);
        bud        = r_idx ^ (IDX_W'(1) << r_ord);
        split_at   = (LINK_W + 1)'(r_blk) + ((LINK_W + 1)'(1) << found_dn);
        alloc_sz   = (LINK_W + 1)'(1) << r_ord;
        fsum       = {1'b0, r_fc} + {1'b0, r_size};
    end

    always_comb begin
        o_sts.req        = r_req;
        o_sts.alloc_bad  = (r_n == '0) || (clog_n > r_limit);
        o_sts.free_bad   = (r_n == '0) || (clog_n >= r_limit) || (LINK_W'(r_bidx) >= NIL);
        o_sts.init_bad   = (r_total == '0) || (r_total > NIL) || (limit5 > 5'(ORDER_SLOTS));
        o_sts.rem_zero   = (r_rem == '0);
        o_sts.srch_end   = (r_found >= r_limit);
        o_sts.head_empty = (head_found >= NIL);
        o_sts.split_end  = (r_found <= r_ord);
        o_sts.chk_top    = (({1'b0, r_ord} + 5'd1) >= {1'b0, r_limit});
        o_sts.walk_end   = (r_steps >= NIL) || (r_cur >= NIL);
        o_sts.walk_hit   = (r_cur == LINK_W'(bud));
        o_sts.out_free   = !r_ovalid || !i_out_stall;
    end

    // link memory port selection
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = head_ord;
        raddr = r_cur[IDX_W-1:0];
        if (i_cmd.init_push) begin
            we    = 1'b1;
            waddr = r_at[IDX_W-1:0];
            wdata = head_init;
        end else if (i_cmd.split_push) begin
            we    = (split_at < (LINK_W + 1)'(POOL_BLOCKS));
            waddr = split_at[IDX_W-1:0];
            wdata = head_split;
        end else if (i_cmd.unl) begin
            we    = r_hasprev;
            waddr = r_prev;
            wdata = r_rdata;
        end else if (i_cmd.free_push) begin
            we    = 1'b1;
        end
        if (i_cmd.pop_rd) raddr = head_found[IDX_W-1:0];
        else if (i_cmd.hit_rd) raddr = bud;
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ORDER_SLOTS; k++) r_head[k] <= NIL;
            r_total  <= NIL;
            r_limit  <= '0;
            r_fc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr) r_total <= i_cfg_data[LINK_W-1:0];
            if (i_cmd.init_start) begin
                for (int k = 0; k < ORDER_SLOTS; k++) r_head[k] <= NIL;
                r_limit <= limit5[ORD_W-1:0];
                r_fc    <= r_total;
            end
            if (i_cmd.init_push) r_head[init_o[SLOT_W-1:0]] <= r_at;
            if (i_cmd.pop_wr) r_head[r_found[SLOT_W-1:0]] <= r_rdata;
            if (i_cmd.split_push && split_at < (LINK_W + 1)'(POOL_BLOCKS))
                r_head[found_dn[SLOT_W-1:0]] <= split_at[LINK_W-1:0];
            if (i_cmd.alloc_fin)
                r_fc <= ({1'b0, r_fc} >= alloc_sz) ? LINK_W'({1'b0, r_fc} - alloc_sz) : '0;
            if (i_cmd.unl && !r_hasprev) r_head[r_ord[SLOT_W-1:0]] <= r_rdata;
            if (i_cmd.free_push) begin
                r_head[r_ord[SLOT_W-1:0]] <= LINK_W'(r_idx);
                r_fc <= (fsum > (LINK_W + 1)'(POOL_BLOCKS)) ? NIL : fsum[LINK_W-1:0];
            end
            if (i_cmd.res_load) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req   <= i_req_type;
            r_n     <= i_req_size;
            r_bidx  <= i_req_base;
            r_where <= '0;
        end
        if (i_cmd.set_st) r_status <= i_cmd.st;
        if (i_cmd.init_start) begin
            r_rem <= r_total;
            r_at  <= '0;
        end
        if (i_cmd.init_push) begin
            r_at  <= r_at + (LINK_W'(1) << init_o);
            r_rem <= r_rem - (LINK_W'(1) << init_o);
        end
        if (i_cmd.alloc_start) begin
            r_ord   <= clog_n;
            r_found <= clog_n;
        end
        if (i_cmd.srch_inc) r_found <= r_found + ORD_W'(1);
        if (i_cmd.pop_rd) r_blk <= head_found[IDX_W-1:0];
        if (i_cmd.split_push) r_found <= found_dn;
        if (i_cmd.alloc_fin) r_where <= r_blk;
        if (i_cmd.free_start) begin
            r_ord  <= clog_n;
            r_idx  <= r_bidx;
            r_size <= LINK_W'(1) << clog_n;
        end
        if (i_cmd.chk_start) begin
            r_cur     <= head_ord;
            r_hasprev <= 1'b0;
            r_steps   <= '0;
        end
        if (i_cmd.walk_rd) begin
            r_prev    <= r_cur[IDX_W-1:0];
            r_hasprev <= 1'b1;
            r_steps   <= r_steps + LINK_W'(1);
        end
        if (i_cmd.next_ld) r_cur <= r_rdata;
        if (i_cmd.unl) begin
            r_idx <= r_idx & ~(IDX_W'(1) << r_ord);
            r_ord <= r_ord + ORD_W'(1);
        end
        if (i_cmd.res_load) begin
            r_o_status <= r_status;
            r_o_where  <= r_where;
            r_o_fc     <= r_fc;
        end
    end

    assign o_cfg_rdata   = 32'(r_total);
    assign o_out_valid   = r_ovalid;
    assign o_status      = r_o_status;
    assign o_alloc_index = r_o_where;
    assign o_free_count  = r_o_fc;

    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= NIL) else $error("free count above pool size");
    a_limit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_limit} <= 5'(ORDER_SLOTS)) else $error("order limit above slot count");
    a_res_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |=> r_ovalid) else $error("result word not presented");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the buddy block allocator: stimulus, in-order prediction and result checking.
`timescale 1ns / 1ps
module tb_top;
    import bba_pkg::*;

    localparam int POOL  = POOL_BLOCKS_DEF;
    localparam int SLOTS = ORDER_SLOTS_DEF;
    localparam logic [10:0] NIL = 11'(POOL);
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef struct {
        logic [1:0]  req;
        logic [10:0] num;
        logic [9:0]  idx;
    } t_req_word;

    typedef struct {
        t_status     st;
        logic [9:0]  where;
        logic [10:0] fcount;
    } t_res_word;

    typedef struct {
        logic [9:0]  idx;
        logic [10:0] num;
    } t_region;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire  [31:0] prdata;
    wire         pready;
    logic        in_valid = 0;
    wire         in_stall;
    logic [1:0]  req_type = '0;
    logic [10:0] req_size = '0;
    logic [9:0]  req_base = '0;
    wire         out_valid;
    logic        out_stall = 0;
    wire  [1:0]  st_out;
    wire  [9:0]  alloc_out;
    wire  [10:0] fcount_out;

    buddy_block_allocator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_req_type(req_type), .i_req_size(req_size), .i_req_base(req_base),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(st_out), .o_alloc_index(alloc_out), .o_free_count(fcount_out)
    );

    initial forever #10 i_clk = ~i_clk;

    // Shadow allocator state
    logic [10:0] pool_total = 11'd1024;
    logic [10:0] link_mem [POOL];
    logic [10:0] head_mem [SLOTS];
    int unsigned top_order = 0;
    int unsigned shadow_free = 0;

    t_req_word  pending_q [$];
    t_res_word  expected_q [$];
    t_region    live_q [$];
    int         mismatches = 0;
    int         sent_words = 0;
    int         got_words = 0;
    int         holdoff = 0;
    bit         held = 0;

    function automatic int unsigned order_of(int unsigned n);
        int unsigned k = 0;
        int unsigned p = 1;
        while (p < n && k < 31) begin
            p = p << 1;
            k++;
        end
        return k;
    endfunction

    function automatic void list_push(int unsigned b, int unsigned k);
        if (b >= POOL || k >= SLOTS) return;
        link_mem[b] = head_mem[k];
        head_mem[k] = 11'(b);
    endfunction

    function automatic bit on_list(int unsigned b, int unsigned k);
        int unsigned cur;
        if (k >= top_order || k >= SLOTS) return 0;
        cur = head_mem[k];
        for (int s = 0; s < POOL && cur < POOL; s++) begin
            if (cur == b) return 1;
            cur = link_mem[cur];
        end
        return 0;
    endfunction

    function automatic void list_remove(int unsigned b, int unsigned k);
        int unsigned cur;
        if (k >= SLOTS || b >= POOL) return;
        cur = head_mem[k];
        if (cur == b) begin
            head_mem[k] = link_mem[b];
            return;
        end
        for (int s = 0; s < POOL && cur < POOL; s++) begin
            if (link_mem[cur] == b) begin
                link_mem[cur] = link_mem[b];
                return;
            end
            cur = link_mem[cur];
        end
    endfunction

    function automatic t_res_word predict_request(t_req_word w);
        t_res_word r;
        int unsigned k, found, blk, lim, rem, at, b;
        r.st = ST_REJECT;
        r.where = '0;
        if (w.req == REQ_INIT) begin
            if (pool_total >= 1 && pool_total <= POOL) begin
                lim = order_of(pool_total) + 1;
                if (lim <= SLOTS) begin
                    top_order = lim;
                    shadow_free = pool_total;
                    for (int i = 0; i < SLOTS; i++) head_mem[i] = NIL;
                    rem = pool_total;
                    k = lim;
                    at = 0;
                    while (rem > 0) begin
                        while (k > 0 && (1 << k) > rem) k--;
                        list_push(at, k);
                        at += 1 << k;
                        rem -= 1 << k;
                    end
                    r.st = ST_DONE;
                end
            end
        end else if (w.req == REQ_ALLOC) begin
            if (w.num != 0) begin
                k = order_of(w.num);
                if (k <= top_order) begin
                    found = k;
                    while (found < top_order && head_mem[found] >= NIL) found++;
                    if (found >= top_order) r.st = ST_NOFREE;
                    else begin
                        blk = head_mem[found];
                        head_mem[found] = link_mem[blk];
                        while (found > k) begin
                            found--;
                            list_push(blk + (1 << found), found);
                        end
                        shadow_free = (shadow_free >= (1 << k)) ? shadow_free - (1 << k) : 0;
                        r.where = 10'(blk);
                        r.st = ST_DONE;
                    end
                end
            end
        end else if (w.req == REQ_FREE) begin
            if (w.num != 0) begin
                k = order_of(w.num);
                if (k < top_order) begin
                    b = w.idx;
                    found = k;
                    // merge upward while the buddy sits on the list of this order
                    while (found + 1 < top_order) begin
                        if (!on_list(b ^ (1 << found), found)) break;
                        list_remove(b ^ (1 << found), found);
                        b = b & ~(1 << found);
                        found++;
                    end
                    list_push(b, found);
                    shadow_free += 1 << k;
                    if (shadow_free > POOL) shadow_free = POOL;
                    r.st = ST_DONE;
                end
            end
        end
        r.fcount = 11'(shadow_free);
        return r;
    endfunction

    task automatic issue(logic [1:0] rq, int unsigned n, int unsigned b);
        t_req_word w;
        t_res_word r;
        t_region g;
        w.req = rq;
        w.num = 11'(n);
        w.idx = 10'(b);
        r = predict_request(w);
        if (rq == REQ_INIT && r.st == ST_DONE) live_q.delete();
        if (rq == REQ_ALLOC && r.st == ST_DONE) begin
            g.idx = r.where;
            g.num = w.num;
            live_q.push_back(g);
        end
        expected_q.push_back(r);
        pending_q.push_back(w);
    endtask

    task automatic write_total(logic [10:0] v);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'(4 * REG_TOTAL); pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        pool_total = v;
    endtask

    task automatic random_request();
        int unsigned r, j, n;
        t_region g;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            n = $urandom_range(0, 19);
            if (n < 12) n = $urandom_range(1, 8);
            else if (n < 18) n = $urandom_range(1, 128);
            else n = $urandom_range(0, 2047);
            issue(REQ_ALLOC, n, $urandom_range(0, 1023));
        end else if (r < 85 && live_q.size() > 0) begin
            j = $urandom_range(0, live_q.size() - 1);
            g = live_q[j];
            live_q.delete(j);
            issue(REQ_FREE, g.num, g.idx);
        end else if (r < 93) begin
            n = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, 16);
            issue(REQ_FREE, n, $urandom_range(0, 1023));
        end else if (r < 97) begin
            issue(REQ_UNKNOWN, $urandom_range(0, 2047), $urandom_range(0, 1023));
        end else begin
            issue(REQ_INIT, $urandom_range(0, 2047), $urandom_range(0, 1023));
        end
    endtask

    // Driver: next word goes out once the current one has been taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) sent_words <= sent_words + 1;
            if (pending_q.size() > 0 &&
                ((sent_words > 300 && sent_words < 450) || $urandom_range(0, 99) >= 10)) begin
                t_req_word w;
                w = pending_q.pop_front();
                req_type <= w.req;
                req_size <= w.num;
                req_base <= w.idx;
                in_valid <= 1;
            end else begin
                in_valid <= 0;
            end
        end
    end

    // Receiver stall, including one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 0;
        end else if (holdoff > 0) begin
            holdoff <= holdoff - 1;
            out_stall <= (holdoff > 1);
        end else if (!held && got_words == 150) begin
            held <= 1;
            holdoff <= 400;
            out_stall <= 1;
        end else begin
            out_stall <= !(got_words > 500 && got_words < 650) && $urandom_range(0, 99) < 10;
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            got_words <= got_words + 1;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word: status %0d", st_out);
            end else begin
                t_res_word e;
                e = expected_q.pop_front();
                if (st_out !== e.st || alloc_out !== e.where || fcount_out !== e.fcount) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch word %0d: exp st %0d idx %0d free %0d, got %0d %0d %0d",
                                 got_words, e.st, e.where, e.fcount, st_out, alloc_out, fcount_out);
                end
            end
        end
    end

    initial begin
        logic [10:0] totals [9] = '{11'd1000, 11'd1, 11'd37, 11'd0, 11'd2047,
                                    11'd512, 11'd3, 11'd1024, 11'd700};
        for (int i = 0; i < POOL; i++) link_mem[i] = '0;
        for (int i = 0; i < SLOTS; i++) head_mem[i] = NIL;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: before init, odd types, extremes of sizes and indexes
        issue(REQ_ALLOC, 1, 0);
        issue(REQ_FREE, 1, 0);
        issue(REQ_UNKNOWN, 2047, 1023);
        issue(REQ_INIT, 0, 0);
        issue(REQ_ALLOC, 0, 0);
        issue(REQ_ALLOC, 2047, 0);
        issue(REQ_ALLOC, 1024, 0);
        issue(REQ_ALLOC, 1, 0);
        issue(REQ_FREE, 1024, 0);
        issue(REQ_ALLOC, 1, 0);
        issue(REQ_ALLOC, 3, 0);
        issue(REQ_ALLOC, 5, 0);
        issue(REQ_FREE, 1, 1023);
        issue(REQ_FREE, 1, 1023);
        issue(REQ_FREE, 0, 5);
        issue(REQ_FREE, 2047, 0);
        issue(REQ_FREE, 1024, 1023);
        issue(REQ_FREE, 4, 4);
        issue(REQ_INIT, 0, 0);

        foreach (totals[p]) begin
            while (expected_q.size() > 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
            write_total(totals[p]);
            issue(REQ_INIT, 0, 0);
            for (int i = 0; i < 105; i++) random_request();
        end

        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #80ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
